// ===== hw/rtl/mtbl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtbl_pkg
// Shared types and codes for the move-to-back list and its storage cells.
// ----------------------------------------------------------------------------
package mtbl_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DUMP   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] value_res;
    logic               last;
  } out_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_NOP    = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_CMP    = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_ROT    = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/mtbl_cell.sv =====
// ----------------------------------------------------------------------------
// mtbl_cell
// One list entry: holds a value, compares it with the search value and takes
// its neighbour's value when the list closes up or rotates.
// ----------------------------------------------------------------------------
module mtbl_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  mtbl_pkg::cell_ctl_t   ctl,
  input  logic [CW-1:0]         count,
  input  logic signed [31:0]    nb_data,
  input  logic signed [31:0]    head_data,
  input  logic                  seen_in,
  output logic signed [31:0]    data,
  output logic                  seen_out
);

  localparam logic [CW-1:0] IdxC    = CW'(IDX);
  localparam logic [CW-1:0] IdxNext = CW'(IDX + 1);

  logic signed [31:0] data_r;
  logic               hit_r;
  logic               is_in;
  logic               is_tail;
  logic               is_app;

  assign is_in   = IdxC < count;
  assign is_tail = count == IdxNext;
  assign is_app  = count == IdxC;

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      mtbl_pkg::CMD_APPEND: begin
        if (is_app) begin
          data_r <= ctl.value;
        end
      end
      mtbl_pkg::CMD_CMP: begin
        hit_r <= is_in && (data_r == ctl.value);
      end
      mtbl_pkg::CMD_MOVE: begin
        if (is_tail) begin
          data_r <= ctl.value;
        end else if (is_in && (seen_in || hit_r)) begin
          data_r <= nb_data;
        end
      end
      mtbl_pkg::CMD_ROT: begin
        if (is_tail) begin
          data_r <= head_data;
        end else if (is_in) begin
          data_r <= nb_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign data     = data_r;
  assign seen_out = seen_in || hit_r;

endmodule

// ===== hw/rtl/move_to_back_list.sv =====
// ----------------------------------------------------------------------------
// move_to_back_list
// Self-organising list of signed 32-bit values kept in a chain of cells.
// ----------------------------------------------------------------------------
// The input channel takes one item per transfer: append, lookup, dump or
// clear. Results leave on the output channel through a single output
// register, one result per transfer, the final one of an item marked last.
// Clear gives no result. A lookup has two steps: all cells compare with the
// search value; then, once the output register is free and on a hit, the first
// hit cell and those behind it take their neighbour's value while the tail cell
// loads the hit value. A dump sends one entry per step while the output register
// is free: the chain rotates towards the head and the head cell is sent out, so
// after a full pass the order is as before. An empty dump gives one result.
// One item is worked on at a time; the next is taken once the current one has
// finished and the output register is free or being emptied.
// Reset empties the list; entry contents are left as they are.
// When the receiver stalls, the block holds its work and takes no input.
// ----------------------------------------------------------------------------
module move_to_back_list #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtbl_pkg::in_t   in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output mtbl_pkg::out_t  out_item
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOVE = 3'b010,
    ST_DUMP = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        dump_left_r, dump_left_nxt;
  logic signed [31:0]   val_r, val_nxt;
  logic                 out_valid_r;
  mtbl_pkg::out_t       out_item_r;
  logic                 emit;
  mtbl_pkg::out_t       emit_item;
  mtbl_pkg::cell_ctl_t  ctl;
  logic                 out_free;
  logic                 in_fire;
  logic                 found;
  logic signed [31:0]   cell_data [DEPTH];
  logic [DEPTH:0]       seen;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign seen[0]  = 1'b0;
  assign found    = seen[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] nb;
    if (i < DEPTH - 1) begin : g_nb
      assign nb = cell_data[i+1];
    end else begin : g_end
      assign nb = '0;
    end
    mtbl_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .nb_data   (nb),
      .head_data (cell_data[0]),
      .seen_in   (seen[i]),
      .data      (cell_data[i]),
      .seen_out  (seen[i+1])
    );
  end

  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    dump_left_nxt       = dump_left_r;
    val_nxt             = val_r;
    emit                = 1'b0;
    emit_item.status    = mtbl_pkg::STAT_OK;
    emit_item.value_res = in_item.value;
    emit_item.last      = 1'b1;
    ctl.cmd             = mtbl_pkg::CMD_NOP;
    ctl.value           = in_item.value;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item.kind)
            mtbl_pkg::KIND_APPEND: begin
              emit = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                emit_item.status = mtbl_pkg::STAT_FULL;
              end else begin
                ctl.cmd   = mtbl_pkg::CMD_APPEND;
                count_nxt = count_r + CW'(1);
              end
            end
            mtbl_pkg::KIND_LOOKUP: begin
              ctl.cmd   = mtbl_pkg::CMD_CMP;
              val_nxt   = in_item.value;
              state_nxt = ST_MOVE;
            end
            mtbl_pkg::KIND_DUMP: begin
              if (count_r == '0) begin
                emit                = 1'b1;
                emit_item.status    = mtbl_pkg::STAT_EMPTY;
                emit_item.value_res = '0;
              end else begin
                dump_left_nxt = count_r;
                state_nxt     = ST_DUMP;
              end
            end
            mtbl_pkg::KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOVE: begin
        ctl.value           = val_r;
        emit_item.value_res = val_r;
        if (out_free) begin
          emit             = 1'b1;
          emit_item.status = found ? mtbl_pkg::STAT_OK : mtbl_pkg::STAT_MISS;
          ctl.cmd          = found ? mtbl_pkg::CMD_MOVE : mtbl_pkg::CMD_NOP;
          state_nxt        = ST_IDLE;
        end
      end
      ST_DUMP: begin
        emit_item.value_res = cell_data[0];
        emit_item.last      = dump_left_r == CW'(1);
        if (out_free) begin
          emit          = 1'b1;
          ctl.cmd       = mtbl_pkg::CMD_ROT;
          dump_left_nxt = dump_left_r - CW'(1);
          if (dump_left_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dump_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_left_r <= dump_left_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_dump_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (dump_left_r != '0) && (dump_left_r <= count_r))
    else $error("dump counter out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_item.kind == mtbl_pkg::KIND_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the list");

  a_move_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MOVE) && out_free) |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("lookup result not delivered");

endmodule
